@@ rtl/qwsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qwsc_pkg: shared types and constants
// Types, constants and register indexes of the quadrature wheel to servo
// channel block.
// ----------------------------------------------------------------------------
package qwsc_pkg;

    localparam int AXES    = 3;
    localparam int AXIS_W  = 2;
    localparam int POT_W   = 10;
    localparam int VALUE_W = 11;
    localparam int DIV_W   = 8;
    localparam int COUNT_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [POT_W-1:0]   POT_CAP       = POT_W'(1000);
    localparam logic [VALUE_W-1:0] CENTER_RESET  = VALUE_W'(1023);
    localparam logic [VALUE_W-1:0] LOW_RESET     = VALUE_W'(172);
    localparam logic [VALUE_W-1:0] HIGH_RESET    = VALUE_W'(1811);
    localparam logic [DIV_W-1:0]   DIVISOR_RESET = DIV_W'(150);

    // Bit 0 is channel A, bit 1 is channel B.
    localparam logic [1:0] LEVELS_RESET = 2'b10;

    localparam int FIFO_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER = 3'd0,
        REG_LOW    = 3'd1,
        REG_HIGH   = 3'd2,
        REG_PAN    = 3'd3,
        REG_TILT   = 3'd4,
        REG_ROLL   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [VALUE_W-1:0] center_value;
        logic [VALUE_W-1:0] low_limit;
        logic [VALUE_W-1:0] high_limit;
        logic [DIV_W-1:0]   pan_divisor;
        logic [DIV_W-1:0]   tilt_divisor;
        logic [DIV_W-1:0]   roll_divisor;
    } cfg_t;

    typedef struct packed {
        logic              is_sample;
        logic [AXIS_W-1:0] axis;
        logic              channel;
        logic              new_level;
        logic              invert;
        logic [POT_W-1:0]  pot_level;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/qwsc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qwsc_front: request intake
// Accepts input requests, drops those aimed at an axis that does not exist,
// and hands the rest to the command queue as classified commands.
// ----------------------------------------------------------------------------
module qwsc_front (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_req_type,
    input  wire  [qwsc_pkg::AXIS_W-1:0]  s_axis,
    input  wire                          s_channel,
    input  wire                          s_new_level,
    input  wire                          s_invert,
    input  wire  [qwsc_pkg::POT_W-1:0]   s_pot_level,
    output logic                         push_valid,
    input  wire                          push_ready,
    output qwsc_pkg::cmd_t               push_cmd
);
    import qwsc_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    logic accept;
    logic axis_ok;

    assign s_ready = !hold_valid_reg || push_ready;
    assign accept  = s_valid && s_ready;
    assign axis_ok = (32'(s_axis) < AXES);

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (push_valid && push_ready) begin
            hold_valid_next = 1'b0;
        end
        if (accept && axis_ok) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_cmd_reg.is_sample <= s_req_type;
            hold_cmd_reg.axis      <= s_axis;
            hold_cmd_reg.channel   <= s_channel;
            hold_cmd_reg.new_level <= s_new_level;
            hold_cmd_reg.invert    <= s_invert;
            hold_cmd_reg.pot_level <= s_pot_level;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

endmodule
`default_nettype wire

@@ rtl/qwsc_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qwsc_fifo: command queue
// Short queue between the intake and the execution unit.
// ----------------------------------------------------------------------------
module qwsc_fifo (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push_valid,
    output logic            push_ready,
    input  qwsc_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  wire             pop_ready,
    output qwsc_pkg::cmd_t  pop_cmd
);
    import qwsc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/qwsc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qwsc_back: execution unit
// Applies edge events to the per-axis decoder state and turns sample
// requests into clamped servo channel values through a bit-serial divider,
// one multiply and a saturate, add and clamp step.
// ----------------------------------------------------------------------------
module qwsc_back (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  qwsc_pkg::cfg_t                cfg,
    input  wire                           pop_valid,
    output logic                          pop_ready,
    input  qwsc_pkg::cmd_t                pop_cmd,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [qwsc_pkg::AXIS_W-1:0]   m_axis_out,
    output logic [qwsc_pkg::VALUE_W-1:0]  m_channel_value
);
    import qwsc_pkg::*;

    localparam int DIV_STEPS = POT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PROD_W    = COUNT_W + POT_W + 1;
    localparam int SUM_W     = COUNT_W + 2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]         lv_reg   [AXES];
    logic [COUNT_W-1:0] pos_reg  [AXES];
    logic [COUNT_W-1:0] samp_reg [AXES];
    logic [1:0]         lv_next;
    logic [COUNT_W-1:0] pos_next;

    logic                     m_valid_reg;
    logic [AXIS_W-1:0]        m_axis_reg;
    logic [VALUE_W-1:0]       m_value_reg;

    logic [AXIS_W-1:0]        axis_reg;
    logic [COUNT_W-1:0]       motion_reg;
    logic [POT_W-1:0]         dq_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         div_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                 pop;
    logic                 edge_write;
    logic                 sample_start;
    logic                 out_load;
    logic                 up;
    logic [1:0]           lv_cur;
    logic [DIV_W-1:0]     div_sel;
    logic [DIV_W:0]       rem_shift;
    logic                 rem_ge;
    logic signed [COUNT_W-1:0] sat;
    logic signed [SUM_W-1:0]   sum;
    logic [VALUE_W-1:0]        clamped;

    assign pop_ready    = (state_reg == ST_IDLE);
    assign pop          = pop_valid && pop_ready;
    assign sample_start = pop && pop_cmd.is_sample;

    // Edge decoding: the stored level is updated first, then the direction
    // comes from the new A and B levels.
    always_comb begin
        lv_cur  = lv_reg[pop_cmd.axis];
        lv_next = lv_cur;
        lv_next[pop_cmd.channel] = pop_cmd.new_level;
        up = pop_cmd.channel ? (lv_next[0] == lv_next[1]) : (lv_next[0] != lv_next[1]);
        up = up ^ pop_cmd.invert;
        pos_next = up ? pos_reg[pop_cmd.axis] + COUNT_W'(1)
                      : pos_reg[pop_cmd.axis] - COUNT_W'(1);
        edge_write = pop && !pop_cmd.is_sample && (lv_cur[pop_cmd.channel] != pop_cmd.new_level);
    end

    always_comb begin
        case (pop_cmd.axis)
            AXIS_W'(0): div_sel = cfg.pan_divisor;
            AXIS_W'(1): div_sel = cfg.tilt_divisor;
            default:    div_sel = cfg.roll_divisor;
        endcase
    end

    assign rem_shift = {rem_reg, dq_reg[POT_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // Saturate the product to 16 bits, add the center and clamp, low limit first.
    always_comb begin
        if (prod_reg > PROD_W'(signed'(32767))) begin
            sat = 16'sh7FFF;
        end else if (prod_reg < -PROD_W'(signed'(32768))) begin
            sat = 16'sh8000;
        end else begin
            sat = prod_reg[COUNT_W-1:0];
        end
        sum = $signed({{(SUM_W-VALUE_W){1'b0}}, cfg.center_value})
            + $signed({{(SUM_W-COUNT_W){sat[COUNT_W-1]}}, sat});
        if (sum < $signed({{(SUM_W-VALUE_W){1'b0}}, cfg.low_limit})) begin
            clamped = cfg.low_limit;
        end else if (sum > $signed({{(SUM_W-VALUE_W){1'b0}}, cfg.high_limit})) begin
            clamped = cfg.high_limit;
        end else begin
            clamped = sum[VALUE_W-1:0];
        end
    end

    assign out_load = (state_reg == ST_SUM) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (sample_start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                lv_reg[i]   <= LEVELS_RESET;
                pos_reg[i]  <= '0;
                samp_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (edge_write) begin
                lv_reg[pop_cmd.axis]  <= lv_next;
                pos_reg[pop_cmd.axis] <= pos_next;
            end
            if (sample_start) begin
                samp_reg[pop_cmd.axis] <= pos_reg[pop_cmd.axis];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sample_start) begin
            axis_reg   <= pop_cmd.axis;
            motion_reg <= pos_reg[pop_cmd.axis] - samp_reg[pop_cmd.axis];
            dq_reg     <= (pop_cmd.pot_level > POT_CAP) ? POT_CAP : pop_cmd.pot_level;
            div_reg    <= (div_sel == '0) ? DIV_W'(1) : div_sel;
            rem_reg    <= '0;
            cnt_reg    <= '0;
        end else if (state_reg == ST_DIV) begin
            // The quotient bits shift in where the dividend bits leave.
            rem_reg <= rem_ge ? DIV_W'(rem_shift - {1'b0, div_reg}) : rem_shift[DIV_W-1:0];
            dq_reg  <= {dq_reg[POT_W-2:0], rem_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'($signed(motion_reg) * $signed({1'b0, dq_reg}));
        end
        if (out_load) begin
            m_axis_reg  <= axis_reg;
            m_value_reg <= clamped;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_axis_out      = m_axis_reg;
    assign m_channel_value = m_value_reg;

    a_load_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_SUM))
        else $error("result appeared outside the final step");

    a_pop_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (state_reg == ST_IDLE))
        else $error("command taken while a sample is in progress");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");

    a_no_edge_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !edge_write)
        else $error("edge event applied while a sample is in progress");

endmodule
`default_nettype wire

@@ rtl/quadrature_wheel_to_servo_channel.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_wheel_to_servo_channel: three-axis x4 decoder with servo output
// Top level: configuration registers, request intake, command queue and
// execution unit.
// ----------------------------------------------------------------------------
// Edge events are applied in the execution unit as they are taken and give
// no result. A sample request goes through a start step there, the bit-serial
// divide of the capped pot reading by the axis divisor (one quotient bit per
// cycle), the multiply and the saturate, add and clamp step that loads the
// output register once it is free. Requests for a nonexistent axis are dropped
// at intake. A two-entry queue separates intake from execution, so requests
// are taken while a sample is being worked out or a result waits.
module quadrature_wheel_to_servo_channel (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire                            s_req_type,
    input  wire  [qwsc_pkg::AXIS_W-1:0]    s_axis,
    input  wire                            s_channel,
    input  wire                            s_new_level,
    input  wire                            s_invert,
    input  wire  [qwsc_pkg::POT_W-1:0]     s_pot_level,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [qwsc_pkg::AXIS_W-1:0]    m_axis_out,
    output logic [qwsc_pkg::VALUE_W-1:0]   m_channel_value,
    input  wire                            cfg_wr_en,
    input  wire  [qwsc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire  [qwsc_pkg::VALUE_W-1:0]   cfg_wr_data
);
    import qwsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_CENTER: cfg_next.center_value = cfg_wr_data;
                REG_LOW:    cfg_next.low_limit    = cfg_wr_data;
                REG_HIGH:   cfg_next.high_limit   = cfg_wr_data;
                REG_PAN:    cfg_next.pan_divisor  = cfg_wr_data[DIV_W-1:0];
                REG_TILT:   cfg_next.tilt_divisor = cfg_wr_data[DIV_W-1:0];
                REG_ROLL:   cfg_next.roll_divisor = cfg_wr_data[DIV_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_value <= CENTER_RESET;
            cfg_reg.low_limit    <= LOW_RESET;
            cfg_reg.high_limit   <= HIGH_RESET;
            cfg_reg.pan_divisor  <= DIVISOR_RESET;
            cfg_reg.tilt_divisor <= DIVISOR_RESET;
            cfg_reg.roll_divisor <= DIVISOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qwsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_axis      (s_axis),
        .s_channel   (s_channel),
        .s_new_level (s_new_level),
        .s_invert    (s_invert),
        .s_pot_level (s_pot_level),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    qwsc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    qwsc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_cmd         (pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_axis_out      (m_axis_out),
        .m_channel_value (m_channel_value)
    );

endmodule
`default_nettype wire

@@ tb/sv/servo_value_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// servo_value_checker: channel value predictor and comparator
// Watches the request, result and register write ports of the quadrature
// wheel to servo channel block. It keeps its own copy of the wheel line
// levels, position counts and settings. It works out the channel value for
// every accepted sample request and compares each result with the oldest
// value still waiting.
// ----------------------------------------------------------------------------
module servo_value_checker (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    input  wire                            s_ready,
    input  wire                            s_req_type,
    input  wire  [qwsc_pkg::AXIS_W-1:0]    s_axis,
    input  wire                            s_channel,
    input  wire                            s_new_level,
    input  wire                            s_invert,
    input  wire  [qwsc_pkg::POT_W-1:0]     s_pot_level,
    input  wire                            m_valid,
    input  wire                            m_ready,
    input  wire  [qwsc_pkg::AXIS_W-1:0]    m_axis_out,
    input  wire  [qwsc_pkg::VALUE_W-1:0]   m_channel_value,
    input  wire                            cfg_wr_en,
    input  wire  [qwsc_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  wire  [qwsc_pkg::VALUE_W-1:0]   cfg_wr_data,
    output int                             mismatches,
    output int                             outstanding,
    output int                             values_checked
);
    import qwsc_pkg::*;

    typedef struct packed {
        logic [AXIS_W-1:0]  axis;
        logic [VALUE_W-1:0] value;
    } servo_value_t;

    cfg_t               settings;
    logic [1:0]         wheel_lines [AXES];
    logic [COUNT_W-1:0] position    [AXES];
    logic [COUNT_W-1:0] sampled     [AXES];
    servo_value_t       expected_values [$];
    int                 error_total = 0;
    int                 checked_total = 0;

    function automatic logic [VALUE_W-1:0] servo_value_for(input logic [AXIS_W-1:0] ax,
                                                           input logic [POT_W-1:0] pot);
        logic [DIV_W-1:0]          divisors [AXES];
        logic signed [COUNT_W-1:0] travel;
        int capped, divisor, gain, motion, delta, total, center, lo, hi;
        divisors = '{settings.pan_divisor, settings.tilt_divisor, settings.roll_divisor};
        capped   = int'((pot > POT_CAP) ? POT_CAP : pot);
        divisor  = int'(divisors[ax]);
        if (divisor == 0) begin
            divisor = 1;
        end
        gain   = capped / divisor;
        travel = position[ax] - sampled[ax];
        motion = int'(travel);
        delta  = motion * gain;
        if (delta > 32767) begin
            delta = 32767;
        end
        if (delta < -32768) begin
            delta = -32768;
        end
        center = int'(settings.center_value);
        lo     = int'(settings.low_limit);
        hi     = int'(settings.high_limit);
        total  = center + delta;
        // The low limit wins the test order, so crossed limits still behave.
        if (total < lo) begin
            total = lo;
        end else if (total > hi) begin
            total = hi;
        end
        return total[VALUE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        servo_value_t want;
        logic [1:0]   lines;
        logic         up;
        if (!aresetn) begin
            settings.center_value = CENTER_RESET;
            settings.low_limit    = LOW_RESET;
            settings.high_limit   = HIGH_RESET;
            settings.pan_divisor  = DIVISOR_RESET;
            settings.tilt_divisor = DIVISOR_RESET;
            settings.roll_divisor = DIVISOR_RESET;
            for (int i = 0; i < AXES; i++) begin
                wheel_lines[i] = LEVELS_RESET;
                position[i]    = '0;
                sampled[i]     = '0;
            end
            expected_values.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    $error("unexpected result: axis_out %0d channel_value %0d",
                           m_axis_out, m_channel_value);
                    error_total++;
                end else begin
                    want = expected_values.pop_front();
                    checked_total++;
                    if (m_axis_out !== want.axis) begin
                        $error("axis_out mismatch: expected %0d, actual %0d",
                               want.axis, m_axis_out);
                        error_total++;
                    end
                    if (m_channel_value !== want.value) begin
                        $error("channel_value mismatch: expected %0d, actual %0d",
                               want.value, m_channel_value);
                        error_total++;
                    end
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    REG_CENTER: settings.center_value = cfg_wr_data;
                    REG_LOW:    settings.low_limit    = cfg_wr_data;
                    REG_HIGH:   settings.high_limit   = cfg_wr_data;
                    REG_PAN:    settings.pan_divisor  = cfg_wr_data[DIV_W-1:0];
                    REG_TILT:   settings.tilt_divisor = cfg_wr_data[DIV_W-1:0];
                    REG_ROLL:   settings.roll_divisor = cfg_wr_data[DIV_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready && s_axis < AXES) begin
                if (s_req_type) begin
                    want.axis  = s_axis;
                    want.value = servo_value_for(s_axis, s_pot_level);
                    expected_values.push_back(want);
                    sampled[s_axis] = position[s_axis];
                end else begin
                    lines = wheel_lines[s_axis];
                    // An edge that leaves the stored level as it was is not an edge.
                    if (lines[s_channel] != s_new_level) begin
                        lines[s_channel]    = s_new_level;
                        wheel_lines[s_axis] = lines;
                        up = s_channel ? (lines[0] == lines[1]) : (lines[0] != lines[1]);
                        if (s_invert) begin
                            up = !up;
                        end
                        position[s_axis] = up ? position[s_axis] + 1'b1
                                              : position[s_axis] - 1'b1;
                    end
                end
            end
        end
        mismatches     <= error_total;
        values_checked <= checked_total;
        outstanding    <= expected_values.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: quadrature wheel to servo channel test
// Drives encoder edges and sample requests into the block under a series of
// register settings, with random gaps on the request side and random stalls
// on the result side. The checker beside the block predicts every channel
// value; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import qwsc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;

    localparam logic REQ_EDGE   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;
    localparam logic CH_A       = 1'b0;
    localparam logic CH_B       = 1'b1;

    localparam logic [AXIS_W-1:0] PAN     = 2'd0;
    localparam logic [AXIS_W-1:0] TILT    = 2'd1;
    localparam logic [AXIS_W-1:0] ROLL    = 2'd2;
    localparam logic [AXIS_W-1:0] NO_AXIS = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_req_type = REQ_EDGE;
    logic [AXIS_W-1:0]    s_axis = PAN;
    logic                 s_channel = CH_A;
    logic                 s_new_level = 1'b0;
    logic                 s_invert = 1'b0;
    logic [POT_W-1:0]     s_pot_level = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [AXIS_W-1:0]    m_axis_out;
    logic [VALUE_W-1:0]   m_channel_value;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = REG_CENTER;
    logic [VALUE_W-1:0]   cfg_wr_data = '0;

    int   mismatches;
    int   outstanding;
    int   values_checked;
    int   cycle_count = 0;
    int   requests_sent = 0;
    int   samples_sent = 0;
    int   settings_used = 0;
    bit   calm = 1'b0;

    // Line levels as the block should see them, so that steps are real edges.
    logic [1:0] wheel_lines [AXES];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    quadrature_wheel_to_servo_channel dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_axis          (s_axis),
        .s_channel       (s_channel),
        .s_new_level     (s_new_level),
        .s_invert        (s_invert),
        .s_pot_level     (s_pot_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_axis_out      (m_axis_out),
        .m_channel_value (m_channel_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    servo_value_checker value_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_axis          (s_axis),
        .s_channel       (s_channel),
        .s_new_level     (s_new_level),
        .s_invert        (s_invert),
        .s_pot_level     (s_pot_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_axis_out      (m_axis_out),
        .m_channel_value (m_channel_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .values_checked  (values_checked)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quadrature_wheel_to_servo_channel verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 8);
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic push_request(input logic req, input logic [AXIS_W-1:0] ax,
                                input logic ch, input logic lvl, input logic inv,
                                input logic [POT_W-1:0] pot);
        while (!calm && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_req_type  <= req;
        s_axis      <= ax;
        s_channel   <= ch;
        s_new_level <= lvl;
        s_invert    <= inv;
        s_pot_level <= pot;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic edge_event(input logic [AXIS_W-1:0] ax, input logic ch,
                              input logic lvl, input logic inv);
        if (ax < AXES) begin
            wheel_lines[ax][ch] = lvl;
        end
        push_request(REQ_EDGE, ax, ch, lvl, inv, POT_W'($urandom_range(1023)));
    endtask

    task automatic sample_axis(input logic [AXIS_W-1:0] ax, input logic [POT_W-1:0] pot);
        push_request(REQ_SAMPLE, ax, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), pot);
        samples_sent++;
    endtask

    // One quadrature step in the wanted direction, with a random invert switch.
    task automatic step_wheel(input logic [AXIS_W-1:0] ax, input logic up);
        logic [1:0] lines;
        logic       inv;
        logic       raw_up;
        logic       ch;
        inv    = 1'($urandom_range(1));
        lines  = wheel_lines[ax];
        raw_up = up ^ inv;
        if (lines[0] == lines[1]) begin
            ch = raw_up ? CH_A : CH_B;
        end else begin
            ch = raw_up ? CH_B : CH_A;
        end
        edge_event(ax, ch, !lines[ch], inv);
    endtask

    task automatic noise_request();
        logic [AXIS_W-1:0] ax;
        ax = AXIS_W'($urandom_range(3));
        if ($urandom_range(1) == 0) begin
            edge_event(ax, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        end else begin
            sample_axis(ax, POT_W'($urandom_range(1023)));
        end
    endtask

    function automatic logic [POT_W-1:0] pick_pot();
        int r;
        r = $urandom_range(9);
        case (r)
            0: return '0;
            1: return '1;
            2: return POT_CAP;
            3: return POT_CAP + 1'b1;
            default: return POT_W'($urandom_range(1023));
        endcase
    endfunction

    // A run of steps on one axis, mostly in one direction, closed by a sample.
    task automatic run_burst(inout int sent);
        logic [AXIS_W-1:0] ax;
        logic              up;
        int                r;
        int                steps;
        ax    = AXIS_W'($urandom_range(AXES - 1));
        up    = 1'($urandom_range(1));
        r     = $urandom_range(99);
        steps = (r < 70) ? $urandom_range(6) :
                (r < 95) ? $urandom_range(40, 8) : $urandom_range(80, 40);
        for (int k = 0; k < steps; k++) begin
            if ($urandom_range(99) < 10) begin
                noise_request();
            end
            if ($urandom_range(99) < 10) begin
                up = !up;
            end
            step_wheel(ax, up);
            sent++;
        end
        sample_axis(($urandom_range(99) < 85) ? ax : AXIS_W'($urandom_range(AXES - 1)),
                    pick_pot());
        sent++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [VALUE_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
    endtask

    // Divisor writes carry random upper bits, which the register drops.
    task automatic load_settings(input cfg_t c);
        write_reg(REG_CENTER, c.center_value);
        write_reg(REG_LOW, c.low_limit);
        write_reg(REG_HIGH, c.high_limit);
        write_reg(REG_PAN, {3'($urandom_range(7)), c.pan_divisor});
        write_reg(REG_TILT, {3'($urandom_range(7)), c.tilt_divisor});
        write_reg(REG_ROLL, {3'($urandom_range(7)), c.roll_divisor});
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // Edge events give no result, so the block may still be busy when the
    // last value has come out; the settle time covers the queue and a divide.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        cfg_t c;
        int   sent;
        for (int i = 0; i < AXES; i++) begin
            wheel_lines[i] = LEVELS_RESET;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        settings_used = 1;

        // Directed requests under the reset settings.
        sample_axis(PAN, '0);
        edge_event(PAN, CH_A, 1'b1, 1'b0);
        edge_event(PAN, CH_A, 1'b1, 1'b0);
        edge_event(PAN, CH_B, 1'b0, 1'b1);
        edge_event(PAN, CH_A, 1'b0, 1'b0);
        sample_axis(PAN, '1);
        edge_event(TILT, CH_B, 1'b0, 1'b0);
        edge_event(TILT, CH_A, 1'b1, 1'b1);
        sample_axis(TILT, POT_CAP);
        sample_axis(TILT, POT_CAP + 1'b1);
        edge_event(NO_AXIS, CH_A, 1'b1, 1'b0);
        sample_axis(NO_AXIS, '1);
        edge_event(ROLL, CH_A, 1'b1, 1'b1);
        sample_axis(ROLL, POT_CAP - 1'b1);
        repeat (8) step_wheel(ROLL, 1'b1);
        sample_axis(ROLL, POT_CAP);
        wait_quiet();

        for (int phase = 0; phase < PHASES; phase++) begin
            c.center_value = VALUE_W'($urandom_range(2047));
            c.low_limit    = VALUE_W'($urandom_range(2047));
            c.high_limit   = VALUE_W'($urandom_range(2047));
            c.pan_divisor  = DIV_W'($urandom_range(255));
            c.tilt_divisor = DIV_W'($urandom_range(255));
            c.roll_divisor = DIV_W'($urandom_range(255));
            case (phase)
                0: begin
                    c.center_value = '1;
                    c.low_limit    = '0;
                    c.high_limit   = '1;
                    c.pan_divisor  = 8'd1;
                    c.tilt_divisor = 8'd1;
                    c.roll_divisor = 8'd1;
                end
                1: begin
                    c.center_value = '0;
                    c.low_limit    = '0;
                    c.high_limit   = '1;
                    c.pan_divisor  = '1;
                    c.tilt_divisor = '1;
                    c.roll_divisor = '1;
                end
                2: begin
                    // Crossed limits and zero divisors.
                    c.low_limit    = 11'd1500;
                    c.high_limit   = 11'd500;
                    c.pan_divisor  = '0;
                    c.tilt_divisor = '0;
                    c.roll_divisor = '0;
                end
                3: c.high_limit = c.low_limit;
                default: ;
            endcase
            load_settings(c);
            calm = (phase == 5);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                run_burst(sent);
            end
            wait_quiet();
        end
        calm = 1'b0;

        $display("Sent %0d requests, %0d of them samples, under %0d register settings.",
                 requests_sent, samples_sent, settings_used);
        $display("Compared %0d channel values: %0d mismatches, %0d never delivered.",
                 values_checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("quadrature_wheel_to_servo_channel verification clean");
        end else begin
            $display("quadrature_wheel_to_servo_channel verification failed");
        end
        $finish;
    end

endmodule
